// ===== rtl/irpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg: shared types and constants for the IR pulse-distance decoder
// Mode codes, configuration register indexes and the decoder state record.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Field widths
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_IDX_W   = 6;
  localparam int unsigned SHIFT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // Data bits per frame (8..32)
  localparam int unsigned FRAME_BITS  = 32;
  localparam logic [BIT_IDX_W-1:0] FRAME_BITS_V = BIT_IDX_W'(FRAME_BITS);

  // Hold counter saturation value
  localparam logic [BYTE_W-1:0] HOLD_MAX = 8'hFF;

  // Input opcodes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Decoder modes
  typedef enum logic [1:0] {
    MODE_LEADER = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOL    = 3'd4;

  // Configuration reset values
  localparam logic [PERIOD_W-1:0] RST_LEADER_PERIOD = 16'd6750;
  localparam logic [PERIOD_W-1:0] RST_ONE_PERIOD    = 16'd1125;
  localparam logic [PERIOD_W-1:0] RST_ZERO_PERIOD   = 16'd562;
  localparam logic [PERIOD_W-1:0] RST_REPEAT_PERIOD = 16'd54000;
  localparam logic [PERIOD_W-1:0] RST_WINDOW_TOL    = 16'd200;

  typedef struct packed {
    logic [PERIOD_W-1:0] leader_period;
    logic [PERIOD_W-1:0] one_period;
    logic [PERIOD_W-1:0] zero_period;
    logic [PERIOD_W-1:0] repeat_period;
    logic [PERIOD_W-1:0] window_tolerance;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [SHIFT_W-1:0]   frame_shift;
    logic [BYTE_W-1:0]    latched_address;
    logic [BYTE_W-1:0]    latched_command;
    logic                 received_flag;
    logic [BYTE_W-1:0]    hold_counter;
  } dec_state_t;

endpackage

// ===== rtl/irpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_if: valid/ready channels of the IR pulse-distance decoder
// Input channel carries edge events and clear requests; output channel
// carries the decoder status after each transaction.
// ----------------------------------------------------------------------------
interface irpd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] edge_period;

  modport source (output valid, output opcode, output edge_period, input ready);
  modport sink   (input valid, input opcode, input edge_period, output ready);
endinterface

interface irpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_byte;
  logic [7:0] command_byte;
  logic       frame_received;
  logic [7:0] hold_count;
  logic [1:0] decoder_mode;

  modport source (output valid, output address_byte, output command_byte,
                  output frame_received, output hold_count, output decoder_mode,
                  input ready);
  modport sink   (input valid, input address_byte, input command_byte,
                  input frame_received, input hold_count, input decoder_mode,
                  output ready);
endinterface

// ===== rtl/irpd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_cfg_regs: configuration register file
// Five 16-bit timing registers written through a plain write port.
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::PERIOD_W-1:0]  cfg_wdata,
  output irpd_pkg::cfg_t                 cfg
);
  import irpd_pkg::*;

  cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_period    <= RST_LEADER_PERIOD;
      cfg_r.one_period       <= RST_ONE_PERIOD;
      cfg_r.zero_period      <= RST_ZERO_PERIOD;
      cfg_r.repeat_period    <= RST_REPEAT_PERIOD;
      cfg_r.window_tolerance <= RST_WINDOW_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEADER_PERIOD: cfg_r.leader_period    <= cfg_wdata;
        CFG_ONE_PERIOD:    cfg_r.one_period       <= cfg_wdata;
        CFG_ZERO_PERIOD:   cfg_r.zero_period      <= cfg_wdata;
        CFG_REPEAT_PERIOD: cfg_r.repeat_period    <= cfg_wdata;
        CFG_WINDOW_TOL:    cfg_r.window_tolerance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/irpd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_step: next-state logic of the decoder
// Window compares, bit classing, frame shift and hold count for one
// transaction.
// ----------------------------------------------------------------------------
module irpd_step (
  input  logic                          opcode,
  input  logic [irpd_pkg::PERIOD_W-1:0] edge_period,
  input  irpd_pkg::cfg_t                cfg,
  input  irpd_pkg::dec_state_t          cur,
  output irpd_pkg::dec_state_t          nxt
);
  import irpd_pkg::*;

  // 17-bit bounds so nothing wraps
  logic [PERIOD_W:0] p_plus_tol;
  logic [PERIOD_W:0] leader_hi;
  logic [PERIOD_W:0] one_hi;
  logic [PERIOD_W:0] zero_hi;
  logic [PERIOD_W:0] repeat_hi;
  logic              in_leader;
  logic              in_one;
  logic              in_zero;
  logic [1:0]        byte_sel;
  logic [BYTE_W-1:0] sel_byte;
  logic [BYTE_W-1:0] new_byte;
  logic [SHIFT_W-1:0] shifted;

  assign p_plus_tol = {1'b0, edge_period} + {1'b0, cfg.window_tolerance};
  assign leader_hi  = {1'b0, cfg.leader_period} + {1'b0, cfg.window_tolerance};
  assign one_hi     = {1'b0, cfg.one_period} + {1'b0, cfg.window_tolerance};
  assign zero_hi    = {1'b0, cfg.zero_period} + {1'b0, cfg.window_tolerance};
  assign repeat_hi  = {1'b0, cfg.repeat_period} + {1'b0, cfg.window_tolerance};

  // nominal - tol < p < nominal + tol
  assign in_leader = ({1'b0, edge_period} < leader_hi) &&
                     (p_plus_tol > {1'b0, cfg.leader_period});
  assign in_one    = ({1'b0, edge_period} < one_hi) &&
                     (p_plus_tol > {1'b0, cfg.one_period});
  assign in_zero   = ({1'b0, edge_period} < zero_hi) &&
                     (p_plus_tol > {1'b0, cfg.zero_period});

  // Shift the classed bit into bit 7 of the current frame byte
  assign byte_sel = cur.bit_index[4:3];
  always_comb begin
    sel_byte = cur.frame_shift[byte_sel*BYTE_W +: BYTE_W];
    new_byte = {in_one, sel_byte[BYTE_W-1:1]};
    shifted  = cur.frame_shift;
    shifted[byte_sel*BYTE_W +: BYTE_W] = new_byte;
  end

  // Mode sequencing
  always_comb begin
    nxt = cur;
    if (opcode == OP_CLEAR) begin
      nxt.received_flag = 1'b0;
    end else begin
      unique case (cur.mode)
        MODE_DATA: begin
          if (cur.bit_index < FRAME_BITS_V) begin
            priority if (in_one || in_zero) begin
              nxt.frame_shift = shifted;
              nxt.bit_index   = cur.bit_index + BIT_IDX_W'(1);
            end else begin
              nxt.mode      = MODE_LEADER;
              nxt.bit_index = '0;
            end
          end else begin
            nxt.mode            = MODE_REPEAT;
            nxt.bit_index       = '0;
            nxt.latched_address = cur.frame_shift[BYTE_W-1:0];
            nxt.latched_command = cur.frame_shift[2*BYTE_W +: BYTE_W];
            nxt.received_flag   = 1'b1;
            nxt.hold_counter    = BYTE_W'(1);
          end
        end
        MODE_REPEAT: begin
          if ({1'b0, edge_period} < repeat_hi) begin
            if (cur.hold_counter != HOLD_MAX) begin
              nxt.hold_counter = cur.hold_counter + BYTE_W'(1);
            end
          end else begin
            nxt.hold_counter = '0;
            nxt.mode         = MODE_LEADER;
          end
        end
        default: begin
          // leader mode, and the unused code treated as leader
          nxt.mode = in_leader ? MODE_DATA : MODE_LEADER;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ir_pulse_distance_decoder_top.sv =====
`timescale 1ns / 1ps
// An accepted transaction enters the input register, its result the result
// register. Throughput: one transaction per cycle while results drain; the
// two registers are parted, so one input is taken while a result waits.
// Reset (rst_n low, synchronous): mode leader, all state zero, timing
// registers to their nominal defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top: pulse-distance IR remote decoder
// Input register, single-pass next-state logic, state and result registers.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  irpd_in_if.sink                        in_chan,
  irpd_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::PERIOD_W-1:0]  cfg_wdata
);
  import irpd_pkg::*;

  cfg_t       cfg;
  dec_state_t state_r;
  dec_state_t state_nxt;

  logic                s1_valid_r;
  logic                s1_opcode_r;
  logic [PERIOD_W-1:0] s1_period_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_addr_r;
  logic [BYTE_W-1:0]   out_cmd_r;
  logic                out_rcv_r;
  logic [BYTE_W-1:0]   out_hold_r;
  mode_t               out_mode_r;

  logic in_accept;
  logic advance;

  irpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irpd_step u_step (
    .opcode      (s1_opcode_r),
    .edge_period (s1_period_r),
    .cfg         (cfg),
    .cur         (state_r),
    .nxt         (state_nxt)
  );

  // Handshake: stage 1 moves on when the result register is free or drains
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_accept      = in_chan.valid && in_chan.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r <= in_chan.opcode;
      s1_period_r <= in_chan.edge_period;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_LEADER, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_addr_r <= state_nxt.latched_address;
      out_cmd_r  <= state_nxt.latched_command;
      out_rcv_r  <= state_nxt.received_flag;
      out_hold_r <= state_nxt.hold_counter;
      out_mode_r <= state_nxt.mode;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.address_byte   = out_addr_r;
  assign out_chan.command_byte   = out_cmd_r;
  assign out_chan.frame_received = out_rcv_r;
  assign out_chan.hold_count     = out_hold_r;
  assign out_chan.decoder_mode   = out_mode_r;

endmodule

// ===== dv/ir_pulse_distance_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top_tb: self-checking bench for the IR decoder
// Sends edge and clear transactions over a valid/ready channel, predicts
// the decoder status for each transaction, and compares every result
// field. It covers default, random and extreme timing windows, with random
// gaps on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top_tb;
  import irpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    logic                op;
    logic [PERIOD_W-1:0] period;
  } edge_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] address_byte;
    logic [BYTE_W-1:0] command_byte;
    logic              frame_received;
    logic [BYTE_W-1:0] hold_count;
    mode_t             decoder_mode;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0] cfg_wdata;

  irpd_in_if  in_ch ();
  irpd_out_if out_ch ();

  ir_pulse_distance_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Pending edge transactions and predicted decoder status
  edge_item_t edge_q[$];
  status_t    status_q[$];
  edge_item_t next_item;
  status_t    want;

  int unsigned cycle_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned pushed_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm;

  // Predictor state: timing registers and decoder state
  cfg_t                 dec_cfg;
  mode_t                dec_mode;
  logic [BIT_IDX_W-1:0] dec_bit_idx;
  logic [SHIFT_W-1:0]   dec_frame;
  logic [BYTE_W-1:0]    dec_address;
  logic [BYTE_W-1:0]    dec_command;
  logic                 dec_rcvd;
  logic [BYTE_W-1:0]    dec_hold;

  // No idling on either side for a stretch of the run
  assign calm = (accepted_cnt >= 150) && (accepted_cnt < 330);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Open window test, bounds at full width
  function automatic logic period_in_window(logic [PERIOD_W-1:0] p,
                                            logic [PERIOD_W-1:0] nominal);
    int unsigned tol;
    tol = dec_cfg.window_tolerance;
    return (p < nominal + tol) && (p + tol > nominal);
  endfunction

  // Advance the decoder by one transaction and return its status
  function automatic status_t decode_step(logic op, logic [PERIOD_W-1:0] p);
    int unsigned pos;
    logic [BYTE_W-1:0] byte_val;
    logic bit_val;
    logic bad;
    status_t s;
    bad = 1'b0;
    bit_val = 1'b0;
    if (op == OP_CLEAR) begin
      dec_rcvd = 1'b0;
    end else begin
      case (dec_mode)
        MODE_DATA: begin
          if (dec_bit_idx < FRAME_BITS) begin
            if (period_in_window(p, dec_cfg.one_period)) bit_val = 1'b1;
            else if (period_in_window(p, dec_cfg.zero_period)) bit_val = 1'b0;
            else bad = 1'b1;
            if (bad) begin
              dec_mode = MODE_LEADER;
              dec_bit_idx = '0;
            end else begin
              // each byte fills from its top bit, LSB first on the wire
              pos = dec_bit_idx[4:3] * 8;
              byte_val = dec_frame[pos +: 8];
              dec_frame[pos +: 8] = {bit_val, byte_val[7:1]};
              dec_bit_idx = dec_bit_idx + 1'b1;
            end
          end else begin
            dec_mode = MODE_REPEAT;
            dec_bit_idx = '0;
            dec_address = dec_frame[7:0];
            dec_command = dec_frame[23:16];
            dec_rcvd = 1'b1;
            dec_hold = 8'd1;
          end
        end
        MODE_REPEAT: begin
          if (p < dec_cfg.repeat_period + int'(dec_cfg.window_tolerance)) begin
            if (dec_hold != HOLD_MAX) dec_hold = dec_hold + 1'b1;
          end else begin
            dec_hold = '0;
            dec_mode = MODE_LEADER;
          end
        end
        default: begin
          dec_mode = period_in_window(p, dec_cfg.leader_period) ? MODE_DATA : MODE_LEADER;
        end
      endcase
    end
    s.address_byte   = dec_address;
    s.command_byte   = dec_command;
    s.frame_received = dec_rcvd;
    s.hold_count     = dec_hold;
    s.decoder_mode   = dec_mode;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Sender: one transaction per slot, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        status_q.push_back(decode_step(in_ch.opcode, in_ch.edge_period));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (edge_q.size() != 0 && (calm || $urandom_range(99, 0) >= 13)) begin
          next_item = edge_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.opcode      <= next_item.op;
          in_ch.edge_period <= next_item.period;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off while input is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && result_cnt >= 400 && in_ch.valid) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99, 0) >= 13);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt <= result_cnt + 1;
      if (status_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        want = status_q.pop_front();
        check_field("address_byte", want.address_byte, out_ch.address_byte);
        check_field("command_byte", want.command_byte, out_ch.command_byte);
        check_field("frame_received", want.frame_received, out_ch.frame_received);
        check_field("hold_count", want.hold_count, out_ch.hold_count);
        check_field("decoder_mode", want.decoder_mode, out_ch.decoder_mode);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_item(logic op, logic [PERIOD_W-1:0] p);
    edge_item_t it;
    it.op = op;
    it.period = p;
    edge_q.push_back(it);
    pushed_cnt++;
  endtask

  // Period strictly inside the window around nominal, random if it is empty
  function automatic logic [PERIOD_W-1:0] pick_near(logic [PERIOD_W-1:0] nominal);
    int lo;
    int hi;
    lo = int'(nominal) - int'(dec_cfg.window_tolerance) + 1;
    hi = int'(nominal) + int'(dec_cfg.window_tolerance) - 1;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (lo > hi) return PERIOD_W'($urandom);
    return PERIOD_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_repeat();
    int hi;
    hi = int'(dec_cfg.repeat_period) + int'(dec_cfg.window_tolerance) - 1;
    if (hi < 0) return PERIOD_W'($urandom);
    if (hi > 65535) hi = 65535;
    return PERIOD_W'($urandom_range(hi, 0));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_release();
    int lo;
    lo = int'(dec_cfg.repeat_period) + int'(dec_cfg.window_tolerance);
    if (lo > 65535) return PERIOD_W'($urandom);
    return PERIOD_W'($urandom_range(65535, lo));
  endfunction

  // Leader, data bits, latch edge, repeats and release; sometimes broken
  task automatic push_frame(int unsigned repeats);
    push_item(OP_EDGE, pick_near(dec_cfg.leader_period));
    for (int b = 0; b < FRAME_BITS; b++) begin
      if ($urandom_range(99, 0) < 4) begin
        push_item(OP_EDGE, PERIOD_W'($urandom));
        return;
      end
      if ($urandom_range(99, 0) < 3) push_item(OP_CLEAR, PERIOD_W'($urandom));
      if ($urandom_range(1, 0) != 0) push_item(OP_EDGE, pick_near(dec_cfg.one_period));
      else push_item(OP_EDGE, pick_near(dec_cfg.zero_period));
    end
    push_item(OP_EDGE, PERIOD_W'($urandom));
    for (int r = 0; r < repeats; r++) begin
      if ($urandom_range(99, 0) < 10) push_item(OP_CLEAR, PERIOD_W'($urandom));
      push_item(OP_EDGE, pick_repeat());
    end
    if ($urandom_range(99, 0) < 85) push_item(OP_EDGE, pick_release());
  endtask

  task automatic push_mix(int unsigned n);
    int unsigned stop;
    int unsigned roll;
    stop = pushed_cnt + n;
    while (pushed_cnt < stop) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) push_frame($urandom_range(6, 0));
      else if (roll < 80) push_item(OP_CLEAR, PERIOD_W'($urandom));
      else if (roll < 85) push_item(OP_EDGE, $urandom_range(1, 0) ? 16'hFFFF : 16'h0000);
      else push_item(OP_EDGE, PERIOD_W'($urandom));
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (edge_q.size() != 0 || in_ch.valid || status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LEADER_PERIOD: dec_cfg.leader_period    = val;
      CFG_ONE_PERIOD:    dec_cfg.one_period       = val;
      CFG_ZERO_PERIOD:   dec_cfg.zero_period      = val;
      CFG_REPEAT_PERIOD: dec_cfg.repeat_period    = val;
      CFG_WINDOW_TOL:    dec_cfg.window_tolerance = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [PERIOD_W-1:0] leader, logic [PERIOD_W-1:0] one,
                            logic [PERIOD_W-1:0] zero, logic [PERIOD_W-1:0] rpt,
                            logic [PERIOD_W-1:0] tol);
    write_reg(CFG_LEADER_PERIOD, leader);
    write_reg(CFG_ONE_PERIOD, one);
    write_reg(CFG_ZERO_PERIOD, zero);
    write_reg(CFG_REPEAT_PERIOD, rpt);
    write_reg(CFG_WINDOW_TOL, tol);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, then phases of stimulus under different timings
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_EDGE;
    in_ch.edge_period = '0;
    out_ch.ready = 1'b0;
    dec_cfg.leader_period    = RST_LEADER_PERIOD;
    dec_cfg.one_period       = RST_ONE_PERIOD;
    dec_cfg.zero_period      = RST_ZERO_PERIOD;
    dec_cfg.repeat_period    = RST_REPEAT_PERIOD;
    dec_cfg.window_tolerance = RST_WINDOW_TOL;
    dec_mode    = MODE_LEADER;
    dec_bit_idx = '0;
    dec_frame   = '0;
    dec_address = '0;
    dec_command = '0;
    dec_rcvd    = 1'b0;
    dec_hold    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, window edges, data classing, bad bit
    push_item(OP_CLEAR, 16'hFFFF);
    push_item(OP_EDGE, 16'd0);
    push_item(OP_EDGE, 16'hFFFF);
    push_item(OP_EDGE, 16'd6550);   // on the lower leader bound: rejected
    push_item(OP_EDGE, 16'd6950);   // on the upper bound: rejected
    push_item(OP_EDGE, 16'd6949);   // leader accepted
    push_item(OP_EDGE, 16'd1324);   // one, top of window
    push_item(OP_EDGE, 16'd926);    // one, bottom of window
    push_item(OP_EDGE, 16'd363);    // zero, bottom of window
    push_item(OP_EDGE, 16'd761);    // zero, top of window
    push_item(OP_EDGE, 16'd925);    // in neither window: abort to leader
    push_item(OP_EDGE, 16'd6551);
    push_item(OP_EDGE, 16'd0);      // bad data bit
    push_item(OP_CLEAR, 16'h0000);
    push_mix(90);
    wait_drain();

    // Random timing
    set_timing($urandom_range(12000, 3000), $urandom_range(2000, 800),
               $urandom_range(800, 200), $urandom_range(65535, 20000),
               $urandom_range(400, 1));
    push_mix(70);
    wait_drain();

    // Zero nominals, widest tolerance: every window accepts all periods but 16'hFFFF
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    push_mix(40);
    wait_drain();

    // Top nominals, narrowest open window
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    push_mix(40);
    wait_drain();

    // Zero tolerance: windows are empty
    set_timing(PERIOD_W'($urandom), PERIOD_W'($urandom), PERIOD_W'($urandom),
               PERIOD_W'($urandom), 16'd0);
    push_mix(20);
    wait_drain();

    // Back to defaults, with a repeat run long enough to saturate the hold count
    set_timing(RST_LEADER_PERIOD, RST_ONE_PERIOD, RST_ZERO_PERIOD,
               RST_REPEAT_PERIOD, RST_WINDOW_TOL);
    push_item(OP_EDGE, 16'd6750);
    for (int b = 0; b < FRAME_BITS; b++)
      push_item(OP_EDGE, $urandom_range(1, 0) ? 16'd1125 : 16'd562);
    push_item(OP_EDGE, 16'd9000);
    for (int r = 0; r < 258; r++) push_item(OP_EDGE, pick_repeat());
    push_item(OP_EDGE, 16'd54200);  // exactly on the release bound
    push_mix(20);
    wait_drain();

    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/irpd_pkg.sv
rtl/irpd_if.sv
rtl/irpd_cfg_regs.sv
rtl/irpd_step.sv
rtl/ir_pulse_distance_decoder_top.sv
dv/ir_pulse_distance_decoder_top_tb.sv
